FILE: hw/rtl/clns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// Holds the transfer descriptor carried from the front end to the back end.
// Depends on nothing.
package clns_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_INIT = 2'd1;
  localparam logic [1:0] KIND_RAW  = 2'd2;

  // Control characters that the character rules treat specially.
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_VTAB    = 8'h0B;
  localparam logic [7:0] CHR_FORMFD  = 8'h0C;
  localparam logic [7:0] CHR_CR      = 8'h0D;

  // Display commands.
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_FUNCSET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY = 8'h0C;
  localparam logic [7:0] CMD_SETADDR = 8'h80;
  localparam logic [7:0] LINE1_ADDR  = 8'h40;
  localparam logic [7:0] INIT_NIBBLE = 8'h02;

  // Hold times in microseconds.
  localparam logic [10:0] HOLD_NONE   = 11'd0;
  localparam logic [10:0] HOLD_STROBE = 11'd1;
  localparam logic [10:0] HOLD_WAIT   = 11'd37;
  localparam logic [10:0] HOLD_CLEAR  = 11'd1637;

  // Pin step numbers within one byte transfer.
  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_HI_EN  = 3'd1;
  localparam logic [2:0] STEP_LOW    = 3'd3;
  localparam logic [2:0] STEP_LO_EN  = 3'd4;
  localparam logic [2:0] STEP_FINAL  = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  // One transfer handed from the front end to the back end.
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic [7:0] code;
    logic       clear_wait; // final hold includes the clear time
    logic       drive;      // drive_on level for every step
    logic       half;       // low nibble only
    logic       last;       // final transfer of its request
  } xfer_t;

endpackage

FILE: hw/rtl/clns_fifo.sv
// Short descriptor queue between the front and back ends of the sequencer.
// Depends on clns_pkg for the descriptor type.
module clns_fifo #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clns_pkg::xfer_t wdata,
  input  logic            pop,
  output clns_pkg::xfer_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clns_pkg::xfer_t mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/clns_front.sv
// Front end: accepts requests, applies the character rules and tracks the line
// and pin-drive state, pushing one descriptor per byte transfer.
// Depends on clns_pkg.
module clns_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic [7:0]      in_code,
  input  logic            in_reg_select,
  input  logic            in_read_write,
  input  logic            q_full,
  output logic            q_push,
  output clns_pkg::xfer_t q_wdata
);

  logic       line_r, line_nxt;
  logic       driven_r, driven_nxt;
  // Next initialize transfer still to push; zero when none is pending.
  logic [1:0] init_r, init_nxt;

  function automatic clns_pkg::xfer_t init_xfer(input logic [1:0] idx);
    clns_pkg::xfer_t d;
    d            = '0;
    d.drive      = 1'b1;
    case (idx)
      2'd0: begin
        d.code = clns_pkg::INIT_NIBBLE;
        d.half = 1'b1;
      end
      2'd1: d.code = clns_pkg::CMD_FUNCSET;
      2'd2: d.code = clns_pkg::CMD_DISPLAY;
      default: begin
        d.code       = clns_pkg::CMD_CLEAR;
        d.clear_wait = 1'b1;
        d.last       = 1'b1;
      end
    endcase
    return d;
  endfunction

  assign in_ready = (init_r == 2'd0) && !q_full;

  always_comb begin
    line_nxt   = line_r;
    driven_nxt = driven_r;
    init_nxt   = init_r;
    q_push     = 1'b0;
    q_wdata    = '0;
    q_wdata.drive = driven_r;
    q_wdata.last  = 1'b1;

    if (init_r != 2'd0) begin
      q_wdata = init_xfer(init_r);
      if (!q_full) begin
        q_push   = 1'b1;
        init_nxt = (init_r == 2'd3) ? 2'd0 : init_r + 2'd1;
      end
    end else if (in_valid && in_ready) begin
      case (in_kind)
        clns_pkg::KIND_CHAR: begin
          q_push = 1'b1;
          case (in_code)
            clns_pkg::CHR_FORMFD: begin
              q_wdata.code       = clns_pkg::CMD_CLEAR;
              q_wdata.clear_wait = 1'b1;
              line_nxt           = 1'b0;
            end
            clns_pkg::CHR_NEWLINE, clns_pkg::CHR_VTAB: begin
              q_wdata.code = line_r ? clns_pkg::CMD_SETADDR
                                    : (clns_pkg::CMD_SETADDR | clns_pkg::LINE1_ADDR);
              line_nxt     = !line_r;
            end
            clns_pkg::CHR_CR: begin
              q_wdata.code = clns_pkg::CMD_SETADDR;
              line_nxt     = 1'b0;
            end
            default: begin
              q_wdata.code = in_code;
              q_wdata.rs   = 1'b1;
            end
          endcase
        end
        clns_pkg::KIND_INIT: begin
          driven_nxt = 1'b1;
          q_push     = 1'b1;
          q_wdata    = init_xfer(2'd0);
          init_nxt   = 2'd1;
        end
        clns_pkg::KIND_RAW: begin
          q_push       = 1'b1;
          q_wdata.code = in_code;
          q_wdata.rs   = in_reg_select;
          q_wdata.rw   = in_read_write;
        end
        default: begin
          // Unused kind: taken and dropped.
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= 1'b0;
      driven_r <= 1'b0;
      init_r   <= 2'd0;
    end else begin
      line_r   <= line_nxt;
      driven_r <= driven_nxt;
      init_r   <= init_nxt;
    end
  end

endmodule

FILE: hw/rtl/clns_back.sv
// Back end: expands each queued transfer into its pin steps, one per cycle unless
// the receiver stalls, into a registered output stage. Depends on clns_pkg.
module clns_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  clns_pkg::xfer_t q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_rs_pin,
  output logic            out_rw_pin,
  output logic [3:0]      out_data_nibble,
  output logic            out_enable_pin,
  output logic            out_drive_on,
  output logic [10:0]     out_hold_us,
  output logic            out_last
);

  clns_pkg::xfer_t cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            out_valid_r;
  logic            rs_r, rw_r, en_r, drv_r, last_r;
  logic [3:0]      nib_r;
  logic [10:0]     hold_r;

  logic            adv;
  logic            en_s;
  logic [3:0]      nib_s;
  logic [10:0]     hold_s;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = !q_empty &&
                 (!cur_valid_r || (adv && step_r == clns_pkg::STEP_FINAL));

  // Pin levels of the current step.
  always_comb begin
    nib_s  = (step_r < clns_pkg::STEP_LOW) ? cur_r.code[7:4] : cur_r.code[3:0];
    en_s   = (step_r == clns_pkg::STEP_HI_EN) || (step_r == clns_pkg::STEP_LO_EN);
    hold_s = clns_pkg::HOLD_NONE;
    if (en_s) begin
      hold_s = clns_pkg::HOLD_STROBE;
    end else if (step_r == clns_pkg::STEP_FINAL) begin
      hold_s = cur_r.clear_wait ? clns_pkg::HOLD_CLEAR : clns_pkg::HOLD_WAIT;
    end
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (q_pop) begin
      cur_nxt       = q_rdata;
      cur_valid_nxt = 1'b1;
      step_nxt      = q_rdata.half ? clns_pkg::STEP_LOW : clns_pkg::STEP_FIRST;
    end else if (cur_valid_r && adv) begin
      if (step_r == clns_pkg::STEP_FINAL) begin
        cur_valid_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (adv) begin
        out_valid_r <= cur_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    step_r <= step_nxt;
    if (adv && cur_valid_r) begin
      rs_r   <= cur_r.rs;
      rw_r   <= cur_r.rw;
      nib_r  <= nib_s;
      en_r   <= en_s;
      drv_r  <= cur_r.drive;
      hold_r <= hold_s;
      last_r <= cur_r.last && (step_r == clns_pkg::STEP_FINAL);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rs_pin      = rs_r;
  assign out_rw_pin      = rw_r;
  assign out_data_nibble = nib_r;
  assign out_enable_pin  = en_r;
  assign out_drive_on    = drv_r;
  assign out_hold_us     = hold_r;
  assign out_last        = last_r;

endmodule

FILE: hw/rtl/char_lcd_nibble_sequencer.sv
// Character LCD sequencer for a 4-bit bus: each request (character, initialize or
// raw transfer) becomes a run of pin steps with hold times in microseconds, and the
// step marked last closes the request. A character or raw transfer gives six steps
// and an initialize gives 21; the single step generator in the back end emits one
// step per cycle unless the receiver stalls. Requests of the unused kind give no
// steps. A queue of QUEUE_DEPTH transfers lets the front end take further requests
// while earlier steps are still going out.
// Depends on clns_pkg, clns_front, clns_fifo and clns_back.
module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_code,
  input  logic        in_reg_select,
  input  logic        in_read_write,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_rs_pin,
  output logic        out_rw_pin,
  output logic [3:0]  out_data_nibble,
  output logic        out_enable_pin,
  output logic        out_drive_on,
  output logic [10:0] out_hold_us,
  output logic        out_last
);

  clns_pkg::xfer_t q_wdata, q_rdata;
  logic            q_push, q_pop, q_full, q_empty;

  clns_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_code       (in_code),
    .in_reg_select (in_reg_select),
    .in_read_write (in_read_write),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  clns_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  clns_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rs_pin      (out_rs_pin),
    .out_rw_pin      (out_rw_pin),
    .out_data_nibble (out_data_nibble),
    .out_enable_pin  (out_enable_pin),
    .out_drive_on    (out_drive_on),
    .out_hold_us     (out_hold_us),
    .out_last        (out_last)
  );

endmodule

FILE: bench/char_lcd_nibble_sequencer_tb.sv
// Self-checking bench for the character LCD nibble sequencer: it sends character,
// initialize and raw requests and checks every pin step against its own prediction.
// Depends on clns_pkg and char_lcd_nibble_sequencer.
module char_lcd_nibble_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic [3:0]  nibble;
    logic        enable;
    logic        drive;
    logic [10:0] hold;
    logic        last;
  } pin_step_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_code;
  logic        in_reg_select;
  logic        in_read_write;
  logic        out_valid;
  logic        out_ready;
  logic        out_rs_pin;
  logic        out_rw_pin;
  logic [3:0]  out_data_nibble;
  logic        out_enable_pin;
  logic        out_drive_on;
  logic [10:0] out_hold_us;
  logic        out_last;

  pin_step_t pending_steps[$];
  int        mismatch_count = 0;
  bit        idle_on = 1'b1;

  // Predicted display state.
  logic on_second_line = 1'b0;
  logic lines_driven = 1'b0;

  char_lcd_nibble_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_code(in_code),
    .in_reg_select(in_reg_select),
    .in_read_write(in_read_write),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rs_pin(out_rs_pin),
    .out_rw_pin(out_rw_pin),
    .out_data_nibble(out_data_nibble),
    .out_enable_pin(out_enable_pin),
    .out_drive_on(out_drive_on),
    .out_hold_us(out_hold_us),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void push_nibble(logic rs, logic rw, logic [3:0] nib,
                                      logic [10:0] tail, logic is_last);
    pending_steps.push_back('{rs, rw, nib, 1'b0, lines_driven, clns_pkg::HOLD_NONE, 1'b0});
    pending_steps.push_back('{rs, rw, nib, 1'b1, lines_driven, clns_pkg::HOLD_STROBE,
                              1'b0});
    pending_steps.push_back('{rs, rw, nib, 1'b0, lines_driven, tail, is_last});
  endfunction

  function automatic void push_byte(logic rs, logic rw, logic [7:0] value,
                                    logic [10:0] tail, logic is_last);
    push_nibble(rs, rw, value[7:4], clns_pkg::HOLD_NONE, 1'b0);
    push_nibble(rs, rw, value[3:0], tail, is_last);
  endfunction

  // Expands one accepted request into the pin steps it should produce.
  function automatic void predict_pin_steps(logic [1:0] kind, logic [7:0] code,
                                            logic rs, logic rw);
    case (kind)
      clns_pkg::KIND_CHAR: begin
        case (code)
          clns_pkg::CHR_FORMFD: begin
            push_byte(1'b0, 1'b0, clns_pkg::CMD_CLEAR, clns_pkg::HOLD_CLEAR, 1'b1);
            on_second_line = 1'b0;
          end
          clns_pkg::CHR_NEWLINE, clns_pkg::CHR_VTAB: begin
            if (on_second_line) begin
              push_byte(1'b0, 1'b0, clns_pkg::CMD_SETADDR, clns_pkg::HOLD_WAIT, 1'b1);
            end else begin
              push_byte(1'b0, 1'b0, clns_pkg::CMD_SETADDR | clns_pkg::LINE1_ADDR,
                        clns_pkg::HOLD_WAIT, 1'b1);
            end
            on_second_line = ~on_second_line;
          end
          clns_pkg::CHR_CR: begin
            push_byte(1'b0, 1'b0, clns_pkg::CMD_SETADDR, clns_pkg::HOLD_WAIT, 1'b1);
            on_second_line = 1'b0;
          end
          default: push_byte(1'b1, 1'b0, code, clns_pkg::HOLD_WAIT, 1'b1);
        endcase
      end
      clns_pkg::KIND_INIT: begin
        // The drivers are already on for the very first step of an initialise.
        lines_driven = 1'b1;
        push_nibble(1'b0, 1'b0, clns_pkg::INIT_NIBBLE[3:0], clns_pkg::HOLD_WAIT, 1'b0);
        push_byte(1'b0, 1'b0, clns_pkg::CMD_FUNCSET, clns_pkg::HOLD_WAIT, 1'b0);
        push_byte(1'b0, 1'b0, clns_pkg::CMD_DISPLAY, clns_pkg::HOLD_WAIT, 1'b0);
        push_byte(1'b0, 1'b0, clns_pkg::CMD_CLEAR, clns_pkg::HOLD_CLEAR, 1'b1);
      end
      clns_pkg::KIND_RAW: push_byte(rs, rw, code, clns_pkg::HOLD_WAIT, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_steps
    pin_step_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected pin step, expected none, got nibble %0h hold %0d",
                 $time, out_data_nibble, out_hold_us);
        mismatch_count++;
      end else begin
        want = pending_steps.pop_front();
        check_field("rs_pin", want.rs, out_rs_pin);
        check_field("rw_pin", want.rw, out_rw_pin);
        check_field("data_nibble", want.nibble, out_data_nibble);
        check_field("enable_pin", want.enable, out_enable_pin);
        check_field("drive_on", want.drive, out_drive_on);
        check_field("hold_us", want.hold, out_hold_us);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Receiver stalls in short bursts while idling is enabled.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [7:0] code, logic rs, logic rw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_code       <= code;
    in_reg_select <= rs;
    in_read_write <= rw;
    do @(posedge clk); while (!in_ready);
    predict_pin_steps(kind, code, rs, rw);
  endtask

  task automatic wait_all_delivered();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
  endtask

  task automatic test_before_init();
    send_request(clns_pkg::KIND_CHAR, 8'h41, 1'b0, 1'b0);
    send_request(KIND_UNUSED, 8'hFF, 1'b1, 1'b1);
    send_request(clns_pkg::KIND_RAW, 8'h33, 1'b1, 1'b1);
  endtask

  task automatic test_initialise();
    send_request(clns_pkg::KIND_INIT, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_control_chars();
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_NEWLINE, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_VTAB, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_NEWLINE, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_CR, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_CR, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_VTAB, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_FORMFD, 1'b0, 1'b0);
  endtask

  task automatic test_data_extremes();
    send_request(clns_pkg::KIND_CHAR, 8'h00, 1'b1, 1'b1);
    send_request(clns_pkg::KIND_CHAR, 8'hFF, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, 8'h7F, 1'b0, 1'b1);
    send_request(clns_pkg::KIND_CHAR, 8'h0E, 1'b1, 1'b0);
  endtask

  task automatic test_raw_transfers();
    send_request(clns_pkg::KIND_RAW, 8'h00, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_RAW, 8'hFF, 1'b1, 1'b1);
    // A raw cursor move to the second line must leave the line flag alone.
    send_request(clns_pkg::KIND_RAW, clns_pkg::CMD_SETADDR | clns_pkg::LINE1_ADDR,
                 1'b0, 1'b0);
    send_request(clns_pkg::KIND_RAW, 8'h5A, 1'b0, 1'b1);
    send_request(clns_pkg::KIND_CHAR, clns_pkg::CHR_NEWLINE, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_RAW, 8'hA5, 1'b1, 1'b0);
  endtask

  task automatic test_unused_kind();
    send_request(KIND_UNUSED, 8'h0C, 1'b0, 1'b0);
    send_request(clns_pkg::KIND_CHAR, 8'h21, 1'b0, 1'b0);
    wait_all_delivered();
  endtask

  task automatic test_random_mix(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_request(clns_pkg::KIND_CHAR, 8'($urandom_range(0, 255)),
                     1'($urandom), 1'($urandom));
      end else if (pick < 65) begin
        send_request(clns_pkg::KIND_CHAR,
                     8'($urandom_range(clns_pkg::CHR_NEWLINE, clns_pkg::CHR_CR)),
                     1'($urandom), 1'($urandom));
      end else if (pick < 83) begin
        send_request(clns_pkg::KIND_RAW, 8'($urandom_range(0, 255)),
                     1'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        send_request(clns_pkg::KIND_INIT, 8'($urandom_range(0, 255)),
                     1'($urandom), 1'($urandom));
      end else begin
        // Ignored requests do not count towards the total.
        send_request(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
        sent--;
      end
      sent++;
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_mix(20);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= clns_pkg::KIND_CHAR;
    in_code       <= 8'h00;
    in_reg_select <= 1'b0;
    in_read_write <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_initialise();
    test_control_chars();
    test_data_extremes();
    test_raw_transfers();
    test_unused_kind();
    test_random_mix(55);
    test_full_rate();

    wait_all_delivered();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/clns_pkg.sv
hw/rtl/clns_fifo.sv
hw/rtl/clns_front.sv
hw/rtl/clns_back.sv
hw/rtl/char_lcd_nibble_sequencer.sv
bench/char_lcd_nibble_sequencer_tb.sv
